// File: design/cbc_pkg.sv
// Shared types, constants and codes of the cell balancer controller.
// No dependencies; every other file of the block imports this package.
package cbc_pkg;

    localparam int MAX_CELLS   = 8;
    localparam int FIELD_CELLS = 8;
    localparam int CELLS       = (MAX_CELLS < FIELD_CELLS) ? MAX_CELLS : FIELD_CELLS;
    localparam int IDX_W       = $clog2(CELLS);
    localparam int CNT_W       = $clog2(CELLS + 1);

    localparam int MV_W   = 16;
    localparam int ERR_W  = 10;
    localparam int CCNT_W = 4;
    localparam int SEC_W  = 16;
    localparam int TIME_W = 32;
    localparam int CMP_W  = MV_W + 2;
    localparam int MASK_W = 8;
    localparam int CFG_W  = 16;

    localparam logic [ERR_W-1:0] RST_ERR    = ERR_W'(3);
    localparam logic [MV_W-1:0]  RST_FLOOR  = MV_W'(3000);
    localparam logic [SEC_W-1:0] RST_MAXSEC = SEC_W'(30);
    localparam logic [MV_W-1:0]  VMAX_INIT  = MV_W'(65535);

    // seconds = (ms * SEC_RECIP) >> SEC_SHIFT, exact for any 32-bit ms value
    localparam int MS_PER_S  = 1000;
    localparam int SEC_SHIFT = 41;
    localparam logic [TIME_W-1:0] SEC_RECIP =
        TIME_W'(((64'd1 << SEC_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

    typedef enum logic [1:0] {
        OP_POWER_ON  = 2'd0,
        OP_STEP      = 2'd1,
        OP_POWER_OFF = 2'd2,
        OP_NOP       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_CELL_COUNT      = 2'd0,
        CFG_ERROR_THRESHOLD = 2'd1,
        CFG_DISCHARGE_FLOOR = 2'd2,
        CFG_MAX_BALANCE_S   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CAPTURE,
        S_LOWEST,
        S_FLOOR,
        S_SPREAD,
        S_START_END,
        S_REF,
        S_PATTERN,
        S_APPLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MV_W-1:0]         cell_v;
        logic [MV_W-1:0]         cell_off;
        logic [MV_W-1:0]         cell_on;
        logic                    adjust;
        logic                    swap;
        logic signed [CMP_W-1:0] base;
        logic [ERR_W-1:0]        addend;
    } t_alu_req;

    typedef struct packed {
        logic signed [CMP_W-1:0] presumed;
        logic                    gt;
    } t_alu_rsp;

endpackage

// File: design/cbc_if.sv
// Handshake channels of the cell balancer controller: item, result, config write.
// Depends on cbc_pkg for field widths.
interface cbc_item_if import cbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [MV_W-1:0]   cell_mv_0;
    logic [MV_W-1:0]   cell_mv_1;
    logic [MV_W-1:0]   cell_mv_2;
    logic [MV_W-1:0]   cell_mv_3;
    logic [MV_W-1:0]   cell_mv_4;
    logic [MV_W-1:0]   cell_mv_5;
    logic [MV_W-1:0]   cell_mv_6;
    logic [MV_W-1:0]   cell_mv_7;
    logic              readings_stable;
    logic              stable_for_start;
    logic [TIME_W-1:0] time_ms;

    modport source (
        output valid, op, cell_mv_0, cell_mv_1, cell_mv_2, cell_mv_3,
               cell_mv_4, cell_mv_5, cell_mv_6, cell_mv_7,
               readings_stable, stable_for_start, time_ms,
        input  ready
    );
    modport sink (
        input  valid, op, cell_mv_0, cell_mv_1, cell_mv_2, cell_mv_3,
               cell_mv_4, cell_mv_5, cell_mv_6, cell_mv_7,
               readings_stable, stable_for_start, time_ms,
        output ready
    );
endinterface

interface cbc_result_if import cbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [MASK_W-1:0] bleed_mask;
    logic              restart_stability;

    modport source (output valid, status, bleed_mask, restart_stability, input ready);
    modport sink   (input valid, status, bleed_mask, restart_stability, output ready);
endinterface

interface cbc_cfg_if import cbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/cbc_cell_unit.sv
// Shared per-cell unit: presumed cell voltage and one signed compare against
// a reference plus offset. Depends on cbc_pkg (t_alu_req, t_alu_rsp).
module cbc_cell_unit import cbc_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [MV_W-1:0]         drift;
    logic signed [CMP_W-1:0] presumed;
    logic signed [CMP_W-1:0] ref_val;

    always_comb begin
        drift = i_req.cell_v + i_req.cell_off - i_req.cell_on;
        // adjusted voltage reads as 16-bit signed, raw voltage as unsigned
        if (i_req.adjust) begin
            presumed = {{(CMP_W-MV_W){drift[MV_W-1]}}, drift};
        end else begin
            presumed = {{(CMP_W-MV_W){1'b0}}, i_req.cell_v};
        end
        ref_val = i_req.base + $signed({{(CMP_W-ERR_W){1'b0}}, i_req.addend});
        o_rsp.presumed = presumed;
        o_rsp.gt       = i_req.swap ? (ref_val > presumed) : (presumed > ref_val);
    end

endmodule

// File: design/cbc_time_unit.sv
// Balance timer: elapsed milliseconds to whole seconds by reciprocal multiply,
// registered, then compared with the limit. Depends on cbc_pkg.
module cbc_time_unit import cbc_pkg::*; (
    input  logic              i_clk,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_start,
    input  logic [SEC_W-1:0]  i_max_s,
    output logic              o_timeout
);

    logic [TIME_W-1:0]   elapsed;
    logic [2*TIME_W-1:0] prod;
    logic [SEC_W-1:0]    r_secs;

    assign elapsed = i_now - i_start;
    assign prod    = {{TIME_W{1'b0}}, elapsed} * {{TIME_W{1'b0}}, SEC_RECIP};

    always_ff @(posedge i_clk) begin
        r_secs <= prod[SEC_SHIFT +: SEC_W];
    end

    assign o_timeout = r_secs > i_max_s;

endmodule

// File: design/cell_balancer_controller.sv
// Cell balancer controller top level: sequencer, state stores, config registers.
// Depends on cbc_pkg, cbc_if, cbc_cell_unit and cbc_time_unit.
//
// Usage:
//   i_item carries one request: op, eight cell voltages, two stability flags and
//   the millisecond time. o_result returns exactly one result per request:
//   status, bleed_mask and restart_stability. i_cfg writes one register per
//   request (index 0 cell count, 1 error, 2 discharge floor, 3 max seconds);
//   it is always ready and is meant to be written while the block is idle.
//   A request is taken only while the sequencer is idle. Work runs over the n
//   active cells, one cell per cycle through the shared cell unit: power on
//   captures each cell, a supervising step builds the pattern over the cells,
//   a starting step finds the lowest cell, checks the spread and builds the
//   pattern; power off and a no-op sweep no cells. The result goes valid as
//   the block becomes ready again. The result sits in an output register, so
//   the next request is accepted while the previous result still waits; a
//   stalled receiver only holds the sequencer once a second result is ready.
//   Reset (synchronous, active low) loads the register defaults, clears the
//   voltage stores and pattern and marks balancing complete.
module cell_balancer_controller import cbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbc_item_if.sink   i_item,
    cbc_result_if.source o_result,
    cbc_cfg_if.sink    i_cfg
);

    t_state r_state, n_state;

    logic [CCNT_W-1:0] r_cell_count;
    logic [ERR_W-1:0]  r_err;
    logic [MV_W-1:0]   r_floor;
    logic [SEC_W-1:0]  r_maxsec;

    t_op               r_op;
    logic [MV_W-1:0]   r_v [CELLS];
    logic              r_stable;
    logic              r_start_ok;
    logic [TIME_W-1:0] r_now;
    logic [CNT_W-1:0]  r_n;

    logic [MV_W-1:0]   r_on  [CELLS];
    logic [MV_W-1:0]   r_off [CELLS];
    logic [MASK_W-1:0] r_pattern, n_pattern;
    logic [MASK_W-1:0] r_driven, n_driven;
    logic              r_finished, n_finished;
    logic              r_on_saved, n_on_saved;
    logic [IDX_W-1:0]  r_lowest, n_lowest;
    logic [TIME_W-1:0] r_start_ms, n_start_ms;

    logic [IDX_W-1:0]        r_cnt, n_cnt;
    logic [MV_W-1:0]         r_minv, n_minv;
    logic signed [CMP_W-1:0] r_vmin, n_vmin;
    logic                    r_spread_off, n_spread_off;
    logic                    r_save, n_save;
    logic                    r_start_path, n_start_path;
    logic [MASK_W-1:0]       r_nb, n_nb;
    logic                    r_status, n_status;
    logic                    r_rewrote, n_rewrote;

    logic              r_out_valid;
    logic              r_out_status;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_restart;

    logic              accept;
    logic              out_load;
    logic              on_we;
    logic              off_we;
    logic              last;
    logic              timeout;
    logic [IDX_W-1:0]  sel_idx;
    logic [ERR_W-1:0]  half;
    logic [MV_W-1:0]   in_mv [FIELD_CELLS];
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    assign in_mv[0] = i_item.cell_mv_0;
    assign in_mv[1] = i_item.cell_mv_1;
    assign in_mv[2] = i_item.cell_mv_2;
    assign in_mv[3] = i_item.cell_mv_3;
    assign in_mv[4] = i_item.cell_mv_4;
    assign in_mv[5] = i_item.cell_mv_5;
    assign in_mv[6] = i_item.cell_mv_6;
    assign in_mv[7] = i_item.cell_mv_7;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid             = r_out_valid;
    assign o_result.status            = r_out_status;
    assign o_result.bleed_mask        = r_out_mask;
    assign o_result.restart_stability = r_out_restart;

    assign last = (CNT_W'(r_cnt) + CNT_W'(1)) == r_n;
    assign half = ERR_W'(({1'b0, r_err} + {{ERR_W{1'b0}}, 1'b1}) >> 1);
    assign sel_idx = (r_state == S_REF) ? r_lowest : r_cnt;

    // Shared cell unit operands
    always_comb begin
        alu_req.cell_v   = r_v[sel_idx];
        alu_req.cell_off = r_off[sel_idx];
        // on-voltages being saved this step count as already written
        alu_req.cell_on  = (r_save && (CNT_W'(sel_idx) < r_n)) ? r_v[sel_idx]
                                                                : r_on[sel_idx];
        alu_req.adjust   = (r_pattern != '0);
        alu_req.swap     = 1'b0;
        alu_req.base     = r_vmin;
        alu_req.addend   = '0;
        unique case (r_state)
            S_LOWEST: begin
                alu_req.swap = 1'b1;
                alu_req.base = {{(CMP_W-MV_W){1'b0}}, r_minv};
            end
            S_SPREAD: begin
                alu_req.addend = r_err;
            end
            S_PATTERN: begin
                alu_req.addend = r_pattern[r_cnt] ? '0 : half;
            end
            default: begin
            end
        endcase
    end

    cbc_cell_unit u_cell (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    cbc_time_unit u_time (
        .i_clk     (i_clk),
        .i_now     (r_now),
        .i_start   (r_start_ms),
        .i_max_s   (r_maxsec),
        .o_timeout (timeout)
    );

    // Sequencer: next state and state updates
    always_comb begin
        n_state      = r_state;
        n_pattern    = r_pattern;
        n_driven     = r_driven;
        n_finished   = r_finished;
        n_on_saved   = r_on_saved;
        n_lowest     = r_lowest;
        n_start_ms   = r_start_ms;
        n_cnt        = r_cnt;
        n_minv       = r_minv;
        n_vmin       = r_vmin;
        n_spread_off = r_spread_off;
        n_save       = r_save;
        n_start_path = r_start_path;
        n_nb         = r_nb;
        n_status     = r_status;
        n_rewrote    = r_rewrote;
        on_we        = 1'b0;
        off_we       = 1'b0;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt     = '0;
                n_rewrote = 1'b0;
                n_save    = 1'b0;
                n_state   = S_DONE;
                unique case (r_op)
                    OP_POWER_ON: begin
                        n_pattern  = '0;
                        n_finished = 1'b0;
                        n_driven   = '0;
                        n_rewrote  = 1'b1;
                        n_status   = 1'b0;
                        if (r_n != '0) begin
                            n_state = S_CAPTURE;
                        end
                    end
                    OP_POWER_OFF: begin
                        n_pattern = '0;
                        if (!r_finished) begin
                            n_driven = '0;
                        end
                        n_finished = 1'b1;
                        n_rewrote  = 1'b1;
                        n_status   = 1'b1;
                    end
                    OP_NOP: begin
                        n_status = r_finished;
                    end
                    OP_STEP: begin
                        n_status = r_finished;
                        priority if (r_finished) begin
                            n_state = S_DONE;
                        end else if (r_stable && (r_pattern == '0)) begin
                            if (r_start_ok) begin
                                n_lowest     = '0;
                                n_minv       = VMAX_INIT;
                                n_on_saved   = 1'b0;
                                n_start_ms   = r_now;
                                n_start_path = 1'b1;
                                n_spread_off = 1'b1;
                                n_state      = (r_n == '0) ? S_FLOOR : S_LOWEST;
                            end
                        end else if (r_stable) begin
                            n_save       = !r_on_saved;
                            n_on_saved   = 1'b1;
                            n_start_path = 1'b0;
                            n_state      = S_REF;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CAPTURE: begin
                on_we  = 1'b1;
                off_we = 1'b1;
                n_cnt  = r_cnt + IDX_W'(1);
                if (last) begin
                    n_state = S_DONE;
                end
            end
            S_LOWEST: begin
                // strict compare keeps the lowest index on ties
                if (alu_rsp.gt) begin
                    n_lowest = r_cnt;
                    n_minv   = r_v[r_cnt];
                end
                n_cnt = r_cnt + IDX_W'(1);
                if (last) begin
                    n_state = S_FLOOR;
                end
            end
            S_FLOOR: begin
                n_vmin = {{(CMP_W-MV_W){1'b0}}, r_v[r_lowest]};
                n_cnt  = '0;
                if ((r_v[r_lowest] >= r_floor) && (r_n != '0)) begin
                    n_state = S_SPREAD;
                end else begin
                    n_state = S_START_END;
                end
            end
            S_SPREAD: begin
                on_we  = 1'b1;
                off_we = 1'b1;
                if (alu_rsp.gt) begin
                    n_spread_off = 1'b0;
                end
                n_cnt = r_cnt + IDX_W'(1);
                if (last) begin
                    n_state = S_START_END;
                end
            end
            S_START_END: begin
                if (r_spread_off) begin
                    n_pattern = '0;
                    if (!r_finished) begin
                        n_driven = '0;
                    end
                    n_finished = 1'b1;
                    n_rewrote  = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_REF;
                end
            end
            S_REF: begin
                n_vmin  = alu_rsp.presumed;
                n_nb    = '0;
                n_cnt   = '0;
                n_state = (r_n == '0) ? S_APPLY : S_PATTERN;
            end
            S_PATTERN: begin
                on_we = r_save;
                n_nb  = r_nb | (MASK_W'(alu_rsp.gt) << r_cnt);
                n_cnt = r_cnt + IDX_W'(1);
                if (last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (r_start_path) begin
                    n_pattern = r_nb;
                    if (!r_finished) begin
                        n_driven = r_nb;
                    end
                    n_rewrote = 1'b1;
                end else if ((r_nb != r_pattern) || timeout) begin
                    // drop all bits on a pattern change or timeout
                    n_pattern = '0;
                    if (!r_finished) begin
                        n_driven = '0;
                    end
                    n_rewrote = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pattern    <= '0;
            r_driven     <= '0;
            r_finished   <= 1'b1;
            r_on_saved   <= 1'b0;
            r_lowest     <= '0;
            r_start_ms   <= '0;
            r_cnt        <= '0;
            r_save       <= 1'b0;
            r_start_path <= 1'b0;
            r_spread_off <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < CELLS; k++) begin
                r_on[k]  <= '0;
                r_off[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_pattern    <= n_pattern;
            r_driven     <= n_driven;
            r_finished   <= n_finished;
            r_on_saved   <= n_on_saved;
            r_lowest     <= n_lowest;
            r_start_ms   <= n_start_ms;
            r_cnt        <= n_cnt;
            r_save       <= n_save;
            r_start_path <= n_start_path;
            r_spread_off <= n_spread_off;
            if (on_we) begin
                r_on[r_cnt] <= r_v[r_cnt];
            end
            if (off_we) begin
                r_off[r_cnt] <= r_v[r_cnt];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_minv    <= n_minv;
        r_vmin    <= n_vmin;
        r_nb      <= n_nb;
        r_status  <= n_status;
        r_rewrote <= n_rewrote;
        if (accept) begin
            r_op       <= t_op'(i_item.op);
            r_stable   <= i_item.readings_stable;
            r_start_ok <= i_item.stable_for_start;
            r_now      <= i_item.time_ms;
            r_n        <= (r_cell_count > CCNT_W'(CELLS)) ? CNT_W'(CELLS)
                                                          : CNT_W'(r_cell_count);
            for (int k = 0; k < CELLS; k++) begin
                r_v[k] <= in_mv[k];
            end
        end
        if (out_load) begin
            r_out_status  <= r_status;
            r_out_mask    <= r_driven;
            r_out_restart <= r_rewrote;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= '0;
            r_err        <= RST_ERR;
            r_floor      <= RST_FLOOR;
            r_maxsec     <= RST_MAXSEC;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CELL_COUNT:      r_cell_count <= i_cfg.data[CCNT_W-1:0];
                CFG_ERROR_THRESHOLD: r_err        <= i_cfg.data[ERR_W-1:0];
                CFG_DISCHARGE_FLOOR: r_floor      <= i_cfg.data[MV_W-1:0];
                CFG_MAX_BALANCE_S:   r_maxsec     <= i_cfg.data[SEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted request did not enter decode");

    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_driven == '0))
        else $error("bleed enables driven while balancing is complete");

    a_driven_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> (r_driven == r_pattern))
        else $error("driven mask differs from pattern while balancing");

    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PATTERN || r_state == S_SPREAD || r_state == S_CAPTURE)
            |-> (CNT_W'(r_cnt) < r_n))
        else $error("cell sweep ran past the active cell count");

endmodule
